### sv/hsv_pkg.sv
// Constants and types for the HSV to RGB565 converter pipeline.
`default_nettype none
package hsv_pkg;

    localparam int unsigned IN_W  = 32;
    localparam int unsigned OUT_W = 40;

    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic [8:0]  HUE_MOD   = 9'd360;
    localparam logic [6:0]  SECT_W    = 7'd60;
    localparam logic [7:0]  FULL      = 8'd255;

    // Reciprocals for constant division, quotient may be one low and is corrected
    localparam logic [15:0] HUE_RECIP = 16'd46603;   // 2^24 / 360
    localparam logic [9:0]  HI_RECIP  = 10'd655;     // 2^16 / 100
    localparam logic [10:0] LO_RECIP  = 11'd1677;    // 2^24 / 10000
    localparam logic [12:0] MID_RECIP = 13'd7130;    // 255 * 2^24 / 600000

    localparam logic [13:0] LO_DIV    = 14'd10000;
    localparam logic [19:0] MID_DIV   = 20'd600000;

    typedef enum logic [2:0] {
        SECT_RED_YEL  = 3'd0,
        SECT_YEL_GRN  = 3'd1,
        SECT_GRN_CYN  = 3'd2,
        SECT_CYN_BLU  = 3'd3,
        SECT_BLU_MAG  = 3'd4,
        SECT_MAG_RED  = 3'd5
    } t_sector;

endpackage
`default_nettype wire

### sv/hsv_to_rgb565_converter.sv
// HSV to RGB565 converter: seven-stage pipeline, one color per cycle while the output is not stalled.
//
//  channel | direction | tdata fields (lowest bit up)
//  --------+-----------+------------------------------------------------------
//  s       | in        | hue[15:0], saturation[23:16], brightness[31:24]
//  m       | out       | rgb565[15:0], red8[23:16], green8[31:24], blue8[39:32]
//
// One item enters per cycle while the output is not stalled; each item passes
// through seven register stages, set by the chain of reciprocal multiplies and
// their corrections.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Each stage holds while its successor is full and stalled, so bubbles are
// squeezed out and a stalled output still lets earlier stages fill.
`default_nettype none
module hsv_to_rgb565_converter import hsv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,   // hue[15:0] saturation[23:16] brightness[31:24]
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata    // rgb565[15:0] red8[23:16] green8[31:24] blue8[39:32]
);

    localparam int unsigned NSTG = 7;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;

    // Stage advances when empty or when the next stage takes its item
    always_comb begin
        en[NSTG] = !r_vld[NSTG] || i_m_tready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_s_tready = en[1];
    assign o_m_tvalid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int i = 2; i <= NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: clamp, hue reciprocal product
    logic [7:0]  in_sat8, in_val8;
    logic [6:0]  n1_sat, n1_val;
    logic [31:0] n1_prodh;
    logic [15:0] r1_hue;
    logic [6:0]  r1_sat, r1_val;
    logic [31:0] r1_prodh;

    assign in_sat8  = i_s_tdata[23:16];
    assign in_val8  = i_s_tdata[31:24];
    assign n1_sat   = (in_sat8 > 8'(PCT_MAX)) ? PCT_MAX : in_sat8[6:0];
    assign n1_val   = (in_val8 > 8'(PCT_MAX)) ? PCT_MAX : in_val8[6:0];
    assign n1_prodh = 32'(i_s_tdata[15:0]) * 32'(HUE_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_hue   <= i_s_tdata[15:0];
            r1_sat   <= n1_sat;
            r1_val   <= n1_val;
            r1_prodh <= n1_prodh;
        end
    end

    // ---------------- stage 2: hue mod 360, channel products
    logic [7:0]  n2_qh;
    logic [15:0] n2_rem;
    logic [8:0]  n2_hh;
    logic [13:0] n2_va;
    logic [14:0] n2_vx;
    logic [8:0]  r2_hh;
    logic [6:0]  r2_sat, r2_val;
    logic [13:0] r2_va;
    logic [14:0] r2_vx;

    always_comb begin
        n2_qh  = r1_prodh[31:24];
        n2_rem = r1_hue - 16'(n2_qh) * 16'(HUE_MOD);
        n2_hh  = (n2_rem >= 16'(HUE_MOD)) ? 9'(n2_rem - 16'(HUE_MOD)) : n2_rem[8:0];
        n2_va  = 14'(r1_val) * 14'(PCT_MAX - r1_sat);
        n2_vx  = 15'(r1_val) * 15'(FULL);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_hh  <= n2_hh;
            r2_sat <= r1_sat;
            r2_val <= r1_val;
            r2_va  <= n2_va;
            r2_vx  <= n2_vx;
        end
    end

    // ---------------- stage 3: sector and ramp, max/min products
    t_sector     n3_sector;
    logic [8:0]  n3_base;
    logic [6:0]  n3_f;
    logic [5:0]  n3_k;
    logic [21:0] n3_lx;
    logic [23:0] n3_prodhi;
    t_sector     r3_sector;
    logic [5:0]  r3_k;
    logic [6:0]  r3_sat, r3_val;
    logic [21:0] r3_lx;
    logic [14:0] r3_vx;
    logic [23:0] r3_prodhi;

    always_comb begin
        if (r2_hh < 9'd60) begin
            n3_sector = SECT_RED_YEL;
        end else if (r2_hh < 9'd120) begin
            n3_sector = SECT_YEL_GRN;
        end else if (r2_hh < 9'd180) begin
            n3_sector = SECT_GRN_CYN;
        end else if (r2_hh < 9'd240) begin
            n3_sector = SECT_CYN_BLU;
        end else if (r2_hh < 9'd300) begin
            n3_sector = SECT_BLU_MAG;
        end else begin
            n3_sector = SECT_MAG_RED;
        end
        if (r2_hh >= 9'd240) begin
            n3_base = 9'd240;
        end else if (r2_hh >= 9'd120) begin
            n3_base = 9'd120;
        end else begin
            n3_base = 9'd0;
        end
        n3_f      = 7'(r2_hh - n3_base);
        n3_k      = (n3_f < SECT_W) ? n3_f[5:0] : 6'(7'd120 - n3_f);
        n3_lx     = 22'(r2_va) * 22'(FULL);
        n3_prodhi = 24'(r2_vx) * 24'(HI_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_sector <= n3_sector;
            r3_k      <= n3_k;
            r3_sat    <= r2_sat;
            r3_val    <= r2_val;
            r3_lx     <= n3_lx;
            r3_vx     <= r2_vx;
            r3_prodhi <= n3_prodhi;
        end
    end

    // ---------------- stage 4: max channel, mid ramp term, min product
    logic [7:0]  n4_qhi;
    logic [14:0] n4_rhi;
    logic [7:0]  n4_hi;
    logic [12:0] n4_t;
    logic [31:0] n4_prodlo;
    t_sector     r4_sector;
    logic [6:0]  r4_val;
    logic [7:0]  r4_hi;
    logic [12:0] r4_t;
    logic [21:0] r4_lx;
    logic [31:0] r4_prodlo;

    always_comb begin
        n4_qhi    = r3_prodhi[23:16];
        n4_rhi    = r3_vx - 15'(n4_qhi) * 15'(PCT_MAX);
        n4_hi     = (n4_rhi >= 15'(PCT_MAX)) ? n4_qhi + 8'd1 : n4_qhi;
        n4_t      = 13'(r3_sat) * 13'(r3_k) + 13'(SECT_W) * 13'(PCT_MAX - r3_sat);
        n4_prodlo = 32'(r3_lx) * 32'(LO_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sector <= r3_sector;
            r4_val    <= r3_val;
            r4_hi     <= n4_hi;
            r4_t      <= n4_t;
            r4_lx     <= r3_lx;
            r4_prodlo <= n4_prodlo;
        end
    end

    // ---------------- stage 5: min channel, mid numerator
    logic [7:0]  n5_qlo;
    logic [21:0] n5_rlo;
    logic [7:0]  n5_lo;
    logic [19:0] n5_u;
    t_sector     r5_sector;
    logic [7:0]  r5_hi, r5_lo;
    logic [19:0] r5_u;

    always_comb begin
        n5_qlo = r4_prodlo[31:24];
        n5_rlo = r4_lx - 22'(n5_qlo) * 22'(LO_DIV);
        n5_lo  = (n5_rlo >= 22'(LO_DIV)) ? n5_qlo + 8'd1 : n5_qlo;
        n5_u   = 20'(r4_val) * 20'(r4_t);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_sector <= r4_sector;
            r5_hi     <= r4_hi;
            r5_lo     <= n5_lo;
            r5_u      <= n5_u;
        end
    end

    // ---------------- stage 6: mid reciprocal product and scaled numerator
    logic [31:0] n6_prodm;
    logic [27:0] n6_um;
    t_sector     r6_sector;
    logic [7:0]  r6_hi, r6_lo;
    logic [31:0] r6_prodm;
    logic [27:0] r6_um;

    assign n6_prodm = 32'(r5_u) * 32'(MID_RECIP);
    assign n6_um    = 28'(r5_u) * 28'(FULL);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_sector <= r5_sector;
            r6_hi     <= r5_hi;
            r6_lo     <= r5_lo;
            r6_prodm  <= n6_prodm;
            r6_um     <= n6_um;
        end
    end

    // ---------------- stage 7: mid channel, sector routing, pack
    logic [7:0]  n7_qm;
    logic [27:0] n7_rm;
    logic [7:0]  n7_mid;
    logic [7:0]  n7_r, n7_g, n7_b;
    logic [15:0] n7_rgb;
    logic [OUT_W-1:0] r7_data;

    always_comb begin
        n7_qm  = r6_prodm[31:24];
        n7_rm  = r6_um - 28'(n7_qm) * 28'(MID_DIV);
        n7_mid = (n7_rm >= 28'(MID_DIV)) ? n7_qm + 8'd1 : n7_qm;
        case (r6_sector)
            SECT_RED_YEL: begin
                n7_r = r6_hi;  n7_g = n7_mid; n7_b = r6_lo;
            end
            SECT_YEL_GRN: begin
                n7_r = n7_mid; n7_g = r6_hi;  n7_b = r6_lo;
            end
            SECT_GRN_CYN: begin
                n7_r = r6_lo;  n7_g = r6_hi;  n7_b = n7_mid;
            end
            SECT_CYN_BLU: begin
                n7_r = r6_lo;  n7_g = n7_mid; n7_b = r6_hi;
            end
            SECT_BLU_MAG: begin
                n7_r = n7_mid; n7_g = r6_lo;  n7_b = r6_hi;
            end
            default: begin
                n7_r = r6_hi;  n7_g = r6_lo;  n7_b = n7_mid;
            end
        endcase
        n7_rgb = {n7_r[7:3], n7_g[7:2], n7_b[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_data <= {n7_b, n7_g, n7_r, n7_rgb};
        end
    end

    assign o_m_tdata = r7_data;

    // ---------------- assertions
    a_pack_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:11] == o_m_tdata[23:19]) &&
                       (o_m_tdata[10:5] == o_m_tdata[31:26]) &&
                       (o_m_tdata[4:0] == o_m_tdata[39:35]))
        else $error("rgb565 field disagrees with channel fields");

    a_hue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r2_hh < HUE_MOD))
        else $error("reduced hue out of range");

    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_k <= 6'(SECT_W)))
        else $error("hue ramp above sector width");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && (&r_vld)))
        else $error("input stalled without a full, stalled pipeline");

endmodule
`default_nettype wire
